### rtl/core/tws_pkg.sv
// Package for the two-wire serial byte master: phases, command codes, pin helpers.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int HalfPeriodW = 10;
  localparam int AckWindowW  = 8;
  localparam int CfgDataW    = 10;

  localparam logic [HalfPeriodW-1:0] HALF_PERIOD_RST = 10'd5;
  localparam logic [AckWindowW-1:0]  ACK_WINDOW_RST  = 8'd100;

  // command codes on the op field
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_WINDOW  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_A   = 4'd1,
    PH_ST_B   = 4'd2,
    PH_ST_C   = 4'd3,
    PH_ST_D   = 4'd4,
    PH_SP_A   = 4'd5,
    PH_SP_B   = 4'd6,
    PH_SP_C   = 4'd7,
    PH_BIT_LO = 4'd8,
    PH_BIT_HI = 4'd9,
    PH_ACK_LO = 4'd10,
    PH_ACK_HI = 4'd11,
    PH_POLL   = 4'd12,
    PH_TAIL   = 4'd13
  } phase_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  localparam pins_t PINS_RST = '{drv: 1'b0, sda: 1'b1, scl: 1'b1};

  // pin levels shown for the whole of a segment
  function automatic pins_t pin_fn(phase_t p, logic [2:0] cmd, logic msb, logic ats);
    pins_t pins;
    logic  wr;
    wr = (cmd == OP_WRITE);
    pins.scl = (p == PH_ST_B) || (p == PH_ST_C) || (p == PH_SP_B) || (p == PH_SP_C) ||
               (p == PH_BIT_HI) || (p == PH_ACK_HI) || (p == PH_POLL);
    unique case (p) inside
      PH_BIT_LO, PH_BIT_HI: begin
        pins.drv = wr;
        pins.sda = wr ? msb : 1'b1;
      end
      PH_ACK_LO, PH_ACK_HI, PH_TAIL: begin
        pins.drv = ~wr;
        pins.sda = wr ? 1'b1 : ~ats;
      end
      PH_POLL: begin
        pins.drv = 1'b0;
        pins.sda = 1'b1;
      end
      PH_ST_A, PH_ST_B, PH_SP_C: begin
        pins.drv = 1'b1;
        pins.sda = 1'b1;
      end
      default: begin
        pins.drv = 1'b1;
        pins.sda = 1'b0;
      end
    endcase
    return pins;
  endfunction

endpackage

### rtl/core/tws_if.sv
// Word channels of the two-wire serial byte master: tick/command in, pin/result out.
`timescale 1ns / 1ps

interface tws_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] wr_byte;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, op, wr_byte, send_ack, sda_sample, input ready);
  modport sink   (input valid, op, wr_byte, send_ack, sda_sample, output ready);
endinterface

interface tws_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       ack_seen;
  logic [7:0] rx_byte;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  ack_seen, rx_byte, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  ack_seen, rx_byte, output ready);
endinterface

### rtl/core/two_wire_serial_byte_master.sv
// Two-wire serial byte master: per-tick bus sequencer with registered result word.
// Usage: every input word is one bus tick. It carries the sampled data pin and,
// while the master is idle, a command (start, stop, write byte, read byte).
// Each accepted word yields exactly one result word with the clock/data pin
// levels for that tick, busy, and on the last tick of a command a done pulse
// with the acknowledge (write) or the received byte (read).
// Output: the result word is registered and valid in the cycle after its input word is taken.
// Throughput: one word per cycle while the output register is free or being read;
// the sequencer state and the output register both advance on every accepted
// word, so input is taken in the same cycle as the previous result is read.
// Stall: when out_if.ready is low with a word pending, in_if.ready drops and
// the pending word holds; no tick is consumed.
// Bus timing: each clock half phase lasts half_period ticks (cfg index 0),
// the acknowledge poll lasts up to ack_window ticks (cfg index 1); zero acts
// as one. Configuration is written through cfg_we/cfg_addr/cfg_wdata.
// Reset: synchronous, active low; the sequencer goes idle with clock high and
// data released, registers return to 5 and 100, and no result is pending.
`timescale 1ns / 1ps

module two_wire_serial_byte_master
  import tws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  tws_in_if.sink              in_if,
  tws_out_if.source           out_if
);

  // configuration
  logic [HalfPeriodW-1:0] half_period_r;
  logic [AckWindowW-1:0]  ack_window_r;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [HalfPeriodW-1:0] tick_r, tick_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [AckWindowW-1:0]  poll_r, poll_nxt;
  logic                   ack_flag_r, ack_flag_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic                   ats_r, ats_nxt;
  pins_t                  pins_r, pins_nxt;

  // result register
  logic       out_valid_r;
  pins_t      res_pins_r, res_pins_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic       ack_out_r, ack_out_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic take;

  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign take        = in_if.valid & in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_window_r  <= ACK_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[HalfPeriodW-1:0];
        CFG_ACK_WINDOW:  ack_window_r  <= cfg_wdata[AckWindowW-1:0];
        default:         half_period_r <= half_period_r;
      endcase
    end
  end

  always_comb begin
    logic [HalfPeriodW-1:0] h;
    logic [AckWindowW-1:0]  w;
    logic                   wr;
    logic                   ent;
    phase_t                 nph;
    logic [2:0]             op;

    h  = (half_period_r == '0) ? HalfPeriodW'(1) : half_period_r;
    w  = (ack_window_r == '0) ? AckWindowW'(1) : ack_window_r;
    op = in_if.op;

    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    poll_nxt     = poll_r;
    ack_flag_nxt = ack_flag_r;
    cmd_nxt      = cmd_r;
    ats_nxt      = ats_r;
    pins_nxt     = pins_r;

    // load a command on an idle tick
    if (phase_r == PH_IDLE && (op == OP_START || op == OP_STOP || op == OP_WRITE ||
                               op == OP_READ)) begin
      cmd_nxt      = op;
      bit_nxt      = '0;
      ack_flag_nxt = 1'b0;
      poll_nxt     = '0;
      ats_nxt      = in_if.send_ack;
      shift_nxt    = (op == OP_WRITE) ? in_if.wr_byte : 8'h00;
      tick_nxt     = '0;
      unique case (op)
        OP_START: phase_nxt = PH_ST_A;
        OP_STOP:  phase_nxt = PH_SP_A;
        default:  phase_nxt = PH_BIT_LO;
      endcase
      pins_nxt = pin_fn(phase_nxt, op, shift_nxt[7], in_if.send_ack);
    end

    // the tick shows the pins as they stand after any command load
    res_pins_nxt = pins_nxt;
    busy_nxt     = 1'b0;
    done_nxt     = 1'b0;
    ack_out_nxt  = 1'b0;
    rx_nxt       = 8'h00;
    wr           = (cmd_nxt == OP_WRITE);
    ent          = 1'b0;
    nph          = phase_nxt;

    if (phase_nxt != PH_IDLE) begin
      busy_nxt = 1'b1;
      if (phase_nxt == PH_POLL) begin
        if (!in_if.sda_sample) begin
          ack_flag_nxt = 1'b1;
          ent          = 1'b1;
          nph          = PH_TAIL;
        end else begin
          poll_nxt = poll_nxt + AckWindowW'(1);
          if (poll_nxt == '0 || poll_nxt >= w) begin
            ent = 1'b1;
            nph = PH_TAIL;
          end
        end
      end else if ({1'b0, tick_nxt} + (HalfPeriodW+1)'(1) >= {1'b0, h}) begin
        ent = 1'b1;
        unique case (phase_nxt)
          PH_ST_A:   nph = PH_ST_B;
          PH_ST_B:   nph = PH_ST_C;
          PH_ST_C:   nph = PH_ST_D;
          PH_SP_A:   nph = PH_SP_B;
          PH_SP_B:   nph = PH_SP_C;
          PH_BIT_LO: nph = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_nxt = {shift_nxt[6:0], wr ? 1'b0 : in_if.sda_sample};
            bit_nxt   = bit_nxt + 4'd1;
            nph       = bit_nxt[3] ? PH_ACK_LO : PH_BIT_LO;
          end
          PH_ACK_LO: nph = PH_ACK_HI;
          PH_ACK_HI: begin
            poll_nxt = '0;
            nph      = wr ? PH_POLL : PH_TAIL;
          end
          default:   nph = PH_IDLE;
        endcase
      end else begin
        tick_nxt = tick_nxt + HalfPeriodW'(1);
      end

      if (ent) begin
        phase_nxt = nph;
        tick_nxt  = '0;
        if (nph != PH_IDLE) begin
          pins_nxt = pin_fn(nph, cmd_nxt, shift_nxt[7], ats_nxt);
        end
      end

      if (phase_nxt == PH_IDLE) begin
        done_nxt = 1'b1;
        if (cmd_nxt == OP_WRITE) begin
          ack_out_nxt = ack_flag_nxt;
        end else if (cmd_nxt == OP_READ) begin
          rx_nxt = shift_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_r      <= '0;
      shift_r    <= '0;
      poll_r     <= '0;
      ack_flag_r <= 1'b0;
      cmd_r      <= OP_TICK;
      ats_r      <= 1'b0;
      pins_r     <= PINS_RST;
    end else if (take) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      poll_r     <= poll_nxt;
      ack_flag_r <= ack_flag_nxt;
      cmd_r      <= cmd_nxt;
      ats_r      <= ats_nxt;
      pins_r     <= pins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: hold while the word waits
  always_ff @(posedge clk) begin
    if (take) begin
      res_pins_r <= res_pins_nxt;
      busy_r     <= busy_nxt;
      done_r     <= done_nxt;
      ack_out_r  <= ack_out_nxt;
      rx_r       <= rx_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.scl_level = res_pins_r.scl;
  assign out_if.sda_level = res_pins_r.sda;
  assign out_if.sda_drive = res_pins_r.drv;
  assign out_if.busy_res  = busy_r;
  assign out_if.done_res  = done_r;
  assign out_if.ack_seen  = ack_out_r;
  assign out_if.rx_byte   = rx_r;

endmodule

### tb/two_wire_serial_byte_master_test.sv
// Testbench for the two-wire serial byte master: scripted and random bus ticks against a predictor.
`timescale 1ns / 1ps

module two_wire_serial_byte_master_test;
  import tws_pkg::*;

  // op values the block must ignore like a plain tick
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] wr_byte;
    logic       send_ack;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rx;
  } bus_word_t;

  typedef struct packed {
    logic [9:0] hp;
    logic [7:0] aw;
    logic [2:0] op;
    logic [7:0] data;
    logic       ack_req;
    logic       sda;
    logic [2:0] busy_op;
    logic       typed;
    bus_word_t  want;
  } step_row_t;

  // words of the last tick of a command, or of an idle tick, as they must look
  localparam bus_word_t W_RESET      = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam bus_word_t W_START_DONE = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam bus_word_t W_WR_NACK    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam bus_word_t W_WR_ACK     = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00};
  localparam bus_word_t W_RD_FF      = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'hFF};
  localparam bus_word_t W_RD_00      = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam bus_word_t W_STOP_DONE  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam bus_word_t W_STOP_IDLE  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam bus_word_t W_NONE       = '0;

  // one command per row; its remaining ticks carry busy_op and the same data level
  localparam step_row_t BUS_SCRIPT [17] = '{
    '{10'd5,    8'd100, OP_TICK,   8'h00, 1'b0, 1'b1, OP_TICK,   1'b1, W_RESET},
    '{10'd5,    8'd100, OP_SPARE5, 8'hFF, 1'b1, 1'b0, OP_TICK,   1'b1, W_RESET},
    '{10'd5,    8'd100, OP_SPARE6, 8'h00, 1'b0, 1'b1, OP_TICK,   1'b1, W_RESET},
    '{10'd5,    8'd100, OP_SPARE7, 8'hFF, 1'b1, 1'b0, OP_TICK,   1'b1, W_RESET},
    '{10'd5,    8'd100, OP_START,  8'h00, 1'b0, 1'b1, OP_STOP,   1'b1, W_START_DONE},
    '{10'd1,    8'd255, OP_WRITE,  8'hFF, 1'b0, 1'b1, OP_TICK,   1'b1, W_WR_NACK},
    '{10'd1,    8'd255, OP_WRITE,  8'h00, 1'b1, 1'b0, OP_READ,   1'b1, W_WR_ACK},
    '{10'd1,    8'd1,   OP_WRITE,  8'hA5, 1'b0, 1'b1, OP_SPARE7, 1'b0, W_NONE},
    '{10'd1,    8'd1,   OP_WRITE,  8'h5A, 1'b1, 1'b0, OP_WRITE,  1'b1, W_WR_ACK},
    '{10'd1,    8'd1,   OP_READ,   8'h00, 1'b1, 1'b1, OP_START,  1'b1, W_RD_FF},
    '{10'd1,    8'd1,   OP_READ,   8'hFF, 1'b0, 1'b0, OP_TICK,   1'b1, W_RD_00},
    '{10'd0,    8'd0,   OP_READ,   8'h00, 1'b1, 1'b1, OP_WRITE,  1'b0, W_NONE},
    '{10'd0,    8'd0,   OP_WRITE,  8'h3C, 1'b0, 1'b1, OP_TICK,   1'b0, W_NONE},
    '{10'd2,    8'd3,   OP_STOP,   8'h00, 1'b0, 1'b0, OP_READ,   1'b1, W_STOP_DONE},
    '{10'd2,    8'd3,   OP_TICK,   8'h00, 1'b0, 1'b1, OP_TICK,   1'b1, W_STOP_IDLE},
    '{10'd3,    8'd2,   OP_READ,   8'h96, 1'b0, 1'b1, OP_TICK,   1'b0, W_NONE},
    '{10'd1,    8'd1,   OP_START,  8'h00, 1'b0, 1'b0, OP_TICK,   1'b0, W_NONE}
  };

  localparam logic [9:0] RAND_HP [6] = '{10'd1, 10'd2, 10'd0, 10'd1, 10'd3, 10'd1};
  localparam logic [7:0] RAND_AW [6] = '{8'd1, 8'd4, 8'd0, 8'd255, 8'd20, 8'd2};
  localparam int TICKS_PER_TIMING = 75;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  tws_in_if  tick_ch ();
  tws_out_if bus_ch ();

  two_wire_serial_byte_master dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_if    (tick_ch),
    .out_if   (bus_ch)
  );

  // bus sequencer mirror
  logic [9:0]  hp_reg;
  logic [7:0]  aw_reg;
  phase_t      bus_ph;
  int unsigned seg_ticks;
  logic [3:0]  bits_done;
  logic [7:0]  shreg;
  logic [7:0]  polls;
  logic        acked;
  logic [2:0]  cmd;
  logic        ack_lvl;
  pins_t       pins_q;

  bus_word_t words_due [$];
  int        fail_count;
  int        ticks_sent;
  int        burst_left;
  int        timings_used;
  int        done_words;
  int        ack_words;
  int        read_words;

  function automatic pins_t phase_pins(phase_t p);
    pins_t pv;
    logic  wr;
    wr = (cmd == OP_WRITE);
    pv.drv = 1'b1;
    pv.sda = 1'b0;
    pv.scl = 1'b0;
    case (p)
      PH_ST_A: pv.sda = 1'b1;
      PH_ST_B: begin
        pv.sda = 1'b1;
        pv.scl = 1'b1;
      end
      PH_ST_C, PH_SP_B: pv.scl = 1'b1;
      PH_SP_C: begin
        pv.sda = 1'b1;
        pv.scl = 1'b1;
      end
      PH_BIT_LO, PH_BIT_HI: begin
        pv.drv = wr;
        pv.sda = wr ? shreg[7] : 1'b1;
        pv.scl = (p == PH_BIT_HI);
      end
      PH_ACK_LO, PH_ACK_HI, PH_TAIL: begin
        pv.drv = !wr;
        pv.sda = wr ? 1'b1 : !ack_lvl;
        pv.scl = (p == PH_ACK_HI);
      end
      PH_POLL: begin
        pv.drv = 1'b0;
        pv.sda = 1'b1;
        pv.scl = 1'b1;
      end
      default: ;
    endcase
    return pv;
  endfunction

  function automatic void go_phase(phase_t p);
    bus_ph = p;
    seg_ticks = 0;
    if (p != PH_IDLE) pins_q = phase_pins(p);
  endfunction

  function automatic void end_segment(logic sda);
    case (bus_ph)
      PH_ST_A:   go_phase(PH_ST_B);
      PH_ST_B:   go_phase(PH_ST_C);
      PH_ST_C:   go_phase(PH_ST_D);
      PH_SP_A:   go_phase(PH_SP_B);
      PH_SP_B:   go_phase(PH_SP_C);
      PH_BIT_LO: go_phase(PH_BIT_HI);
      PH_BIT_HI: begin
        // shift out on a write, shift in the sampled level on a read
        shreg = (cmd == OP_WRITE) ? {shreg[6:0], 1'b0} : {shreg[6:0], sda};
        bits_done = bits_done + 4'd1;
        go_phase(bits_done >= 4'd8 ? PH_ACK_LO : PH_BIT_LO);
      end
      PH_ACK_LO: go_phase(PH_ACK_HI);
      PH_ACK_HI: begin
        polls = '0;
        go_phase(cmd == OP_WRITE ? PH_POLL : PH_TAIL);
      end
      default:   go_phase(PH_IDLE);
    endcase
  endfunction

  function automatic bus_word_t next_bus_word(tick_t t);
    bus_word_t   res;
    int unsigned h;
    int unsigned w;
    h = (hp_reg == '0) ? 1 : hp_reg;
    w = (aw_reg == '0) ? 1 : aw_reg;
    res = '0;
    if (bus_ph == PH_IDLE && t.op >= OP_START && t.op <= OP_READ) begin
      cmd = t.op;
      bits_done = '0;
      acked = 1'b0;
      polls = '0;
      ack_lvl = t.send_ack;
      shreg = (t.op == OP_WRITE) ? t.wr_byte : 8'h00;
      case (t.op)
        OP_START: go_phase(PH_ST_A);
        OP_STOP:  go_phase(PH_SP_A);
        default:  go_phase(PH_BIT_LO);
      endcase
    end
    // the word shows the pins as they stand after any command load, before the tick advances
    res.scl = pins_q.scl;
    res.sda = pins_q.sda;
    res.drv = pins_q.drv;
    if (bus_ph != PH_IDLE) begin
      res.busy = 1'b1;
      if (bus_ph == PH_POLL) begin
        if (!t.sda_sample) begin
          acked = 1'b1;
          go_phase(PH_TAIL);
        end else begin
          polls = polls + 8'd1;
          if (polls == 8'd0 || polls >= w) go_phase(PH_TAIL);
        end
      end else if (seg_ticks + 1 >= h) begin
        end_segment(t.sda_sample);
      end else begin
        seg_ticks = seg_ticks + 1;
      end
      if (bus_ph == PH_IDLE) begin
        res.done = 1'b1;
        if (cmd == OP_WRITE) res.ack = acked;
        else if (cmd == OP_READ) res.rx = shreg;
      end
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // result side: stall in changing patterns, with stretches of none
  initial begin
    int cyc;
    int mode;
    bus_ch.ready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       bus_ch.ready <= 1'b1;
        1:       bus_ch.ready <= 1'($urandom);
        2:       bus_ch.ready <= (cyc % 5 != 0);
        default: bus_ch.ready <= (cyc % 8 == 7);
      endcase
      cyc++;
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    bus_word_t want;
    if (rst_n && bus_ch.valid && bus_ch.ready) begin
      if (words_due.size() == 0) begin
        fail_count++;
        $error("bus word with none due");
      end else begin
        want = words_due.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(bus_ch.scl_level));
        check_field("sda_level", 8'(want.sda), 8'(bus_ch.sda_level));
        check_field("sda_drive", 8'(want.drv), 8'(bus_ch.sda_drive));
        check_field("busy_res", 8'(want.busy), 8'(bus_ch.busy_res));
        check_field("done_res", 8'(want.done), 8'(bus_ch.done_res));
        check_field("ack_seen", 8'(want.ack), 8'(bus_ch.ack_seen));
        check_field("rx_byte", want.rx, bus_ch.rx_byte);
        if (want.done) begin
          done_words++;
          if (want.ack) ack_words++;
          if (want.rx != 8'h00) read_words++;
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_tick(input tick_t t, input logic typed, input bus_word_t want);
    int        gap;
    bus_word_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    tick_ch.valid      <= 1'b1;
    tick_ch.op         <= t.op;
    tick_ch.wr_byte    <= t.wr_byte;
    tick_ch.send_ack   <= t.send_ack;
    tick_ch.sda_sample <= t.sda_sample;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    res = next_bus_word(t);
    if (typed && bus_ph == PH_IDLE) res = want;
    words_due.push_back(res);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words();
    tick_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_bus_timing(input logic [9:0] hp, input logic [7:0] aw);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(negedge clk);
    cfg_addr  <= CFG_ACK_WINDOW;
    // upper bits lie beyond the register and must be dropped
    cfg_wdata <= {2'($urandom_range(0, 3)), aw};
    @(negedge clk);
    cfg_we <= 1'b0;
    hp_reg = hp;
    aw_reg = aw;
    timings_used++;
  endtask

  task automatic run_random(input int n);
    tick_t t;
    int    low_odds;
    low_odds = 1;
    repeat (n) begin
      if (bus_ph == PH_IDLE) begin
        // how eagerly the far end holds data low during the next command
        low_odds = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 8) t.op = 3'($urandom_range(OP_START, OP_READ));
        else t.op = 3'($urandom_range(0, 7));
      end else begin
        t.op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
      end
      t.wr_byte    = 8'($urandom);
      t.send_ack   = 1'($urandom);
      t.sda_sample = ($urandom_range(0, 3) < low_odds) ? 1'b0 : 1'b1;
      send_tick(t, 1'b0, W_NONE);
      if ($urandom_range(0, 199) == 0) drain_words();
    end
  endtask

  initial begin
    step_row_t row;
    tick_t     t;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = CFG_HALF_PERIOD;
    cfg_wdata          = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.op         = OP_TICK;
    tick_ch.wr_byte    = '0;
    tick_ch.send_ack   = 1'b0;
    tick_ch.sda_sample = 1'b1;
    hp_reg     = HALF_PERIOD_RST;
    aw_reg     = ACK_WINDOW_RST;
    bus_ph     = PH_IDLE;
    seg_ticks  = 0;
    bits_done  = '0;
    shreg      = '0;
    polls      = '0;
    acked      = 1'b0;
    cmd        = OP_TICK;
    ack_lvl    = 1'b0;
    pins_q.scl = 1'b1;
    pins_q.sda = 1'b1;
    pins_q.drv = 1'b0;
    fail_count   = 0;
    ticks_sent   = 0;
    burst_left   = 0;
    timings_used = 1;
    done_words   = 0;
    ack_words    = 0;
    read_words   = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (BUS_SCRIPT[i]) begin
      row = BUS_SCRIPT[i];
      if (row.hp != hp_reg || row.aw != aw_reg) begin
        drain_words();
        set_bus_timing(row.hp, row.aw);
      end
      t.op         = row.op;
      t.wr_byte    = row.data;
      t.send_ack   = row.ack_req;
      t.sda_sample = row.sda;
      send_tick(t, row.typed, row.want);
      while (bus_ph != PH_IDLE) begin
        t.op       = row.busy_op;
        t.wr_byte  = 8'($urandom);
        t.send_ack = 1'($urandom);
        send_tick(t, row.typed, row.want);
      end
    end

    // slowest timing, then cut it short while a write is under way
    drain_words();
    set_bus_timing(10'd1023, 8'd100);
    t.op         = OP_WRITE;
    t.wr_byte    = 8'($urandom);
    t.send_ack   = 1'b0;
    t.sda_sample = 1'b1;
    send_tick(t, 1'b0, W_NONE);
    t.op = OP_TICK;
    repeat (40) send_tick(t, 1'b0, W_NONE);
    drain_words();
    set_bus_timing(10'd1, 8'd5);
    run_random(60);

    foreach (RAND_HP[i]) begin
      drain_words();
      set_bus_timing(RAND_HP[i], RAND_AW[i]);
      run_random(TICKS_PER_TIMING);
    end

    drain_words();
    repeat (5) @(negedge clk);
    $display("Covered %0d bus ticks over %0d timing settings.", ticks_sent, timings_used);
    $display("Checked %0d finished commands: %0d acknowledged writes, %0d non-zero read bytes.",
             done_words, ack_words, read_words);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
